// File: rtl/core/assert_macros.svh
// assertion helpers used by sha256_digest_out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    // schedule window taps used by one round
    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w9;
        word_t w14;
    } sched_taps_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } state_t;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] PRE_LEN   = 6'd55;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    // element 0 is word a
    localparam hash_t H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_message_hasher.sv
`default_nettype none
// SHA-256 over a byte stream.
// Input channel (in_valid / in_stall): each beat carries cmd and data_byte.
//   cmd append adds data_byte to the message; cmd finish pads the message,
//   hashes it and queues the 256-bit digest.
// Output channel (out_valid / out_stall): eight beats per finish, word 0
//   (most significant) first, last_word set on word 7.
// An append beat is taken while in_stall is low. The beat that fills a 64-byte
//   block starts the compression: all 64 rounds on the single round unit, then
//   the hash update, with in_stall high.
// A finish shifts in the padding one byte per cycle, length bytes last, and
//   runs one or two compressions with in_stall high: one when it lands on byte
//   55 of a block or before, two from 56, and it waits while the buffer still
//   drains the previous digest; the first word is valid the cycle after the
//   digest is loaded, then one word per cycle while out_stall is low.
// The output buffer frees the core: the next message may stream in while the
//   digest drains. A second digest waits until the buffer has emptied.
// Reset clears the byte count and loads the initial hash values; no memory
//   clearing is needed.
// A stalled output beat holds its word, index and last flag.

module sha256_message_hasher
    import sha256_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire        cmd,
    input  wire [7:0]  data_byte,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0] word_index,
    output logic       last_word
);

    state_t        state_reg, state_next;
    hash_t         hash_reg, hash_next;
    hash_t         wv_reg, wv_next;
    logic [511:0]  msg_reg, msg_next;
    logic [60:0]   count_reg, count_next;
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   len_reg, len_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic          fin_reg, fin_next;
    logic          last_reg, last_next;

    logic          accept;
    logic          load;
    logic          out_busy;
    sched_taps_t   taps;
    hash_t         wv_round;
    word_t         w_new;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // fixed taps of the schedule window, word 0 at the top
    assign taps.w0  = msg_reg[511:480];
    assign taps.w1  = msg_reg[479:448];
    assign taps.w9  = msg_reg[223:192];
    assign taps.w14 = msg_reg[63:32];

    sha256_round u_round (
        .wv_in  (wv_reg),
        .taps   (taps),
        .rnd    (rnd_reg),
        .wv_out (wv_round),
        .w_new  (w_new)
    );

    sha256_digest_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .digest_in   (hash_reg),
        .busy        (out_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fill_reg == LAST_POS)
                        state_next = ST_ROUND;
                    else if (cmd == CMD_FINISH && fill_reg == PRE_LEN)
                        state_next = ST_LEN;
                    else if (cmd == CMD_FINISH)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LAST_POS)
                    state_next = ST_ROUND;
                else if (fill_reg == PRE_LEN)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if (fill_reg == LAST_POS)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == LAST_RND)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (last_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_PAD;
            end
            ST_DONE:
            begin
                if (!out_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        hash_next  = hash_reg;
        wv_next    = wv_reg;
        msg_next   = msg_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        last_next  = last_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_reg + 6'd1;
                    if (cmd == CMD_APPEND)
                    begin
                        msg_next   = {msg_reg[503:0], data_byte};
                        count_next = count_reg + 61'd1;
                    end
                    else
                    begin
                        msg_next = {msg_reg[503:0], PAD_BYTE};
                        fin_next = 1'b1;
                        len_next = {count_reg, 3'b000};
                    end
                    if (fill_reg == LAST_POS)
                    begin
                        wv_next  = hash_reg;
                        rnd_next = 6'd0;
                    end
                end
            end
            ST_PAD:
            begin
                msg_next  = {msg_reg[503:0], 8'h00};
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS)
                begin
                    wv_next  = hash_reg;
                    rnd_next = 6'd0;
                end
            end
            ST_LEN:
            begin
                msg_next  = {msg_reg[503:0], len_reg[63:56]};
                len_next  = {len_reg[55:0], 8'h00};
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS)
                begin
                    wv_next   = hash_reg;
                    rnd_next  = 6'd0;
                    last_next = 1'b1;
                end
            end
            ST_ROUND:
            begin
                wv_next  = wv_round;
                msg_next = {msg_reg[479:0], w_new};
                rnd_next = rnd_reg + 6'd1;
            end
            ST_ADD:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    hash_next[j] = hash_reg[j] + wv_reg[j];
                end
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    load       = 1'b1;
                    hash_next  = H_INIT;
                    count_next = 61'd0;
                    fin_next   = 1'b0;
                    last_next  = 1'b0;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hash_reg  <= H_INIT;
            count_reg <= 61'd0;
            fill_reg  <= 6'd0;
            rnd_reg   <= 6'd0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            last_reg  <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        msg_reg <= msg_next;
        len_reg <= len_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/sha256_round.sv
`default_nettype none

module sha256_round
    import sha256_pkg::*;
(
    input  wire hash_t       wv_in,
    input  wire sched_taps_t taps,
    input  wire [5:0]        rnd,
    output hash_t            wv_out,
    output word_t            w_new
);

    word_t s0, s1, sig0, sig1, ch, maj, t1, t2;

    // next schedule word from the window taps
    always_comb
    begin
        s0    = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
        s1    = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
        w_new = s1 + taps.w9 + s0 + taps.w0;
    end

    // one compression round
    always_comb
    begin
        sig1 = rotr(wv_in[4], 6) ^ rotr(wv_in[4], 11) ^ rotr(wv_in[4], 25);
        ch   = (wv_in[4] & wv_in[5]) ^ (~wv_in[4] & wv_in[6]);
        t1   = wv_in[7] + sig1 + ch + round_k(rnd) + taps.w0;
        sig0 = rotr(wv_in[0], 2) ^ rotr(wv_in[0], 13) ^ rotr(wv_in[0], 22);
        maj  = (wv_in[0] & wv_in[1]) ^ (wv_in[0] & wv_in[2]) ^ (wv_in[1] & wv_in[2]);
        t2   = sig0 + maj;
        wv_out[7] = wv_in[6];
        wv_out[6] = wv_in[5];
        wv_out[5] = wv_in[4];
        wv_out[4] = wv_in[3] + t1;
        wv_out[3] = wv_in[2];
        wv_out[2] = wv_in[1];
        wv_out[1] = wv_in[0];
        wv_out[0] = t1 + t2;
    end

endmodule

`default_nettype wire

// File: rtl/core/sha256_digest_out.sv
`default_nettype none
`include "assert_macros.svh"

module sha256_digest_out
    import sha256_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        load,
    input  wire hash_t digest_in,
    output logic       busy,
    output logic       out_valid,
    input  wire        out_stall,
    output word_t      digest_word,
    output logic [2:0] word_index,
    output logic       last_word
);

    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    hash_t      dig_reg, dig_next;
    logic       beat;

    assign beat = busy_reg && !out_stall;

    // beat sequencing
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        dig_next  = dig_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
            dig_next  = digest_in;
        end
        else if (beat)
        begin
            dig_next = {32'd0, dig_reg[7:1]};
            idx_next = idx_reg + 3'd1;
            if (idx_reg == LAST_WORD)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign busy        = busy_reg;
    assign out_valid   = busy_reg;
    assign digest_word = dig_reg[0];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_WORD);

    // a new digest only lands in an empty buffer
    `SHA_ASSERT_IMP(a_load_idle, clk, rst_n, load, !busy_reg)
    // a fresh digest starts at word zero
    `SHA_ASSERT_NXT(a_load_start, clk, rst_n, load, busy_reg && idx_reg == 3'd0)
    // the final beat empties the buffer
    `SHA_ASSERT_NXT(a_last_drain, clk, rst_n, beat && idx_reg == LAST_WORD && !load,
                    !busy_reg)

endmodule

`default_nettype wire
